@@ sv/bwa_pkg.sv @@
// Shared widths, codes and sequencer states of the bitmap word allocator.
`timescale 1ns / 1ps

package bwa_pkg;

   localparam int WORD_UNITS_DEFAULT = 64;

   localparam int OP_W     = 2;
   localparam int SIZE_W   = 19;
   localparam int ALIGN_W  = 3;
   localparam int ADDR_W   = 18;
   localparam int STATUS_W = 3;
   localparam int FREE_W   = 19;
   localparam int SHIFT_W  = 4;

   localparam logic [OP_W-1:0] OP_ALLOC      = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_MARK = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE_SIZE  = 2'd2;
   localparam logic [OP_W-1:0] OP_FREE_MARK  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOMARK  = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_PREP,
      S_SCAN,
      S_MASK,
      S_MSCAN,
      S_RELEASE,
      S_COUNT,
      S_SUM
   } state_type;

endpackage

@@ sv/bwa_channels.sv @@
// Request and response channel interfaces of the bitmap word allocator.
`timescale 1ns / 1ps

interface bwa_req_if;
   logic                         valid;
   logic                         ready;
   logic [bwa_pkg::OP_W-1:0]     op;
   logic [bwa_pkg::SIZE_W-1:0]   size_bytes;
   logic [bwa_pkg::ALIGN_W-1:0]  align_log2;
   logic [bwa_pkg::ADDR_W-1:0]   address;

   modport source (output valid, op, size_bytes, align_log2, address, input ready);
   modport sink (input valid, op, size_bytes, align_log2, address, output ready);
endinterface

interface bwa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bwa_pkg::STATUS_W-1:0]  status;
   logic [bwa_pkg::ADDR_W-1:0]    offset;
   logic [bwa_pkg::FREE_W-1:0]    free_bytes;

   modport source (output valid, status, offset, free_bytes, input ready);
   modport sink (input valid, status, offset, free_bytes, output ready);
endinterface

@@ sv/bitmap_word_allocator.sv @@
// Bitmap word allocator: first-fit allocate and free over one word of units.
// The request channel takes one transaction at a time: allocate, allocate with
// an end mark on the run's last unit, free by size, or free up to the first
// end mark at or after the given offset. Every request yields exactly one
// response transaction with a status, the allocated byte offset and the free
// bytes that remain. The unit size is set by a single write-only register
// (log2 of bytes per unit) that should only be written while the block idles.
// An allocation walks the aligned candidate positions one per cycle with a
// single shifted-window compare; a free by end mark walks the mark bits one
// per cycle. The free count comes from a two-stage registered popcount.
// An allocation passes through setup, prep, the position scan, count and sum;
// a free by size through setup, prep, mask, release, count and sum; a free by
// end mark walks the mark bits in place of mask, and goes to count if no mark
// turns up; a request refused by its first checks goes from prep to count.
// Ready is low from acceptance until the response is loaded into the output
// register, so a new request is accepted only once the previous one is done.
// A stalled receiver is buffered by the output register; the next request is
// accepted and processed while the old response waits, and its own result
// waits in the final step until the register frees up. Reset (synchronous,
// active high) frees every unit, clears all end marks and sets one-byte units.
`timescale 1ns / 1ps

module bitmap_word_allocator #(
   parameter int WORD_UNITS = bwa_pkg::WORD_UNITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   bwa_req_if.sink                     req_ch,
   bwa_rsp_if.source                   rsp_ch,
   input  logic                        csr_write_enable,
   input  logic [bwa_pkg::SHIFT_W-1:0] csr_write_data
);

   localparam int PW    = $clog2(WORD_UNITS);
   localparam int PADW  = 1 << PW;
   localparam int EW    = PW + 2;
   localparam int UW    = bwa_pkg::SIZE_W + 1;
   localparam int NG    = (WORD_UNITS + 7) / 8;
   localparam int GW    = NG * 8;
   localparam int CW    = $clog2(WORD_UNITS + 1);
   localparam int IDX_W = 6;

   function automatic logic [3:0] count8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int k = 0; k < 8; k++) begin
         n = n + 4'(v[k]);
      end
      return n;
   endfunction

   bwa_pkg::state_type state_ff, state_in;

   logic [WORD_UNITS-1:0]          free_map_ff, free_map_in;
   logic [WORD_UNITS-1:0]          end_marks_ff, end_marks_in;
   logic [bwa_pkg::SHIFT_W-1:0]    unit_shift_ff;

   logic [bwa_pkg::OP_W-1:0]       op_ff, op_in;
   logic [bwa_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic [bwa_pkg::ALIGN_W-1:0]    alog_ff, alog_in;
   logic [bwa_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [UW-1:0]                  units_ff, units_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [WORD_UNITS-1:0]          lowmask_ff, lowmask_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic [WORD_UNITS-1:0]          rel_mask_ff, rel_mask_in;
   logic [bwa_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [bwa_pkg::ADDR_W-1:0]     offset_ff, offset_in;
   logic [3:0]                     part_ff [NG];
   logic [3:0]                     part_in [NG];

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bwa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [bwa_pkg::ADDR_W-1:0]     rsp_offset_ff, rsp_offset_in;
   logic [bwa_pkg::FREE_W-1:0]     rsp_free_ff, rsp_free_in;

   logic [PADW-1:0]                free_pad;
   logic [PADW-1:0]                end_pad;
   logic [GW-1:0]                  free_grp;
   logic [WORD_UNITS-1:0]          window;
   logic                           fit;
   logic [EW-1:0]                  next_pos;
   logic [EW-1:0]                  last_unit;
   logic [UW:0]                    idx_end;
   logic [CW-1:0]                  total;
   logic                           wide_align;

   assign free_pad = PADW'(free_map_ff);
   assign end_pad  = PADW'(end_marks_ff);
   assign free_grp = GW'(free_map_ff);
   assign window   = free_map_ff >> pos_ff;
   assign fit      = (window & lowmask_ff) == lowmask_ff;
   // Alignments of at least the padded word size leave position zero only.
   assign wide_align = 32'(alog_ff) >= PW;
   assign next_pos   = EW'(pos_ff) + (EW'(1) << alog_ff);
   assign last_unit  = EW'(pos_ff) + EW'(units_ff) - EW'(1);
   assign idx_end    = (UW + 1)'(idx_ff) + (UW + 1)'(units_ff);

   always_comb begin
      total = '0;
      for (int g = 0; g < NG; g++) begin
         total = total + CW'(part_ff[g]);
      end
   end

   assign req_ch.ready      = state_ff == bwa_pkg::S_IDLE;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.offset     = rsp_offset_ff;
   assign rsp_ch.free_bytes = rsp_free_ff;

   always_comb begin
      state_in      = state_ff;
      free_map_in   = free_map_ff;
      end_marks_in  = end_marks_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      alog_in       = alog_ff;
      addr_in       = addr_ff;
      units_in      = units_ff;
      idx_in        = idx_ff;
      lowmask_in    = lowmask_ff;
      pos_in        = pos_ff;
      rel_mask_in   = rel_mask_ff;
      status_in     = status_ff;
      offset_in     = offset_ff;
      part_in       = part_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_free_in   = rsp_free_ff;

      case (state_ff)
         bwa_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.op;
               size_in  = req_ch.size_bytes;
               alog_in  = req_ch.align_log2;
               addr_in  = req_ch.address;
               state_in = bwa_pkg::S_SETUP;
            end
         end
         bwa_pkg::S_SETUP: begin
            units_in = (UW'(size_ff) + ((UW'(1) << unit_shift_ff) - UW'(1))) >> unit_shift_ff;
            idx_in   = IDX_W'(addr_ff >> unit_shift_ff);
            state_in = bwa_pkg::S_PREP;
         end
         bwa_pkg::S_PREP: begin
            lowmask_in = ~({WORD_UNITS{1'b1}} << units_ff);
            offset_in  = '0;
            case (op_ff)
               bwa_pkg::OP_ALLOC, bwa_pkg::OP_ALLOC_MARK: begin
                  if (units_ff == '0 || units_ff > UW'(WORD_UNITS)) begin
                     status_in = bwa_pkg::STATUS_NOSPACE;
                     state_in  = bwa_pkg::S_COUNT;
                  end else begin
                     pos_in   = '0;
                     state_in = bwa_pkg::S_SCAN;
                  end
               end
               bwa_pkg::OP_FREE_SIZE: begin
                  if (idx_end > (UW + 1)'(WORD_UNITS)) begin
                     status_in = bwa_pkg::STATUS_RANGE;
                     state_in  = bwa_pkg::S_COUNT;
                  end else begin
                     state_in = bwa_pkg::S_MASK;
                  end
               end
               default: begin
                  if (32'(idx_ff) >= WORD_UNITS || free_pad[idx_ff[PW-1:0]]) begin
                     status_in = bwa_pkg::STATUS_NOMARK;
                     state_in  = bwa_pkg::S_COUNT;
                  end else begin
                     pos_in   = idx_ff[PW-1:0];
                     state_in = bwa_pkg::S_MSCAN;
                  end
               end
            endcase
         end
         bwa_pkg::S_SCAN: begin
            if (fit) begin
               free_map_in = free_map_ff & ~(lowmask_ff << pos_ff);
               if (op_ff == bwa_pkg::OP_ALLOC_MARK) begin
                  end_marks_in = end_marks_ff | (WORD_UNITS'(1) << last_unit);
               end
               status_in = bwa_pkg::STATUS_OK;
               offset_in = bwa_pkg::ADDR_W'(pos_ff) << unit_shift_ff;
               state_in  = bwa_pkg::S_COUNT;
            end else if (wide_align ||
                         next_pos + EW'(units_ff) > EW'(WORD_UNITS)) begin
               status_in = bwa_pkg::STATUS_NOSPACE;
               state_in  = bwa_pkg::S_COUNT;
            end else begin
               pos_in = next_pos[PW-1:0];
            end
         end
         bwa_pkg::S_MASK: begin
            rel_mask_in = lowmask_ff << idx_ff;
            state_in    = bwa_pkg::S_RELEASE;
         end
         bwa_pkg::S_MSCAN: begin
            if (end_pad[pos_ff]) begin
               // The run spans from the start unit through the mark, inclusive.
               rel_mask_in = ({WORD_UNITS{1'b1}} << idx_ff) &
                             ~({WORD_UNITS{1'b1}} << (EW'(pos_ff) + EW'(1)));
               end_marks_in = end_marks_ff & ~(WORD_UNITS'(1) << pos_ff);
               state_in     = bwa_pkg::S_RELEASE;
            end else if (pos_ff == PW'(WORD_UNITS - 1)) begin
               status_in = bwa_pkg::STATUS_NOMARK;
               state_in  = bwa_pkg::S_COUNT;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end
         bwa_pkg::S_RELEASE: begin
            status_in   = (free_map_ff & rel_mask_ff) != '0 ?
                          bwa_pkg::STATUS_DOUBLE : bwa_pkg::STATUS_OK;
            free_map_in = free_map_ff | rel_mask_ff;
            state_in    = bwa_pkg::S_COUNT;
         end
         bwa_pkg::S_COUNT: begin
            for (int g = 0; g < NG; g++) begin
               part_in[g] = count8(free_grp[g*8 +: 8]);
            end
            state_in = bwa_pkg::S_SUM;
         end
         bwa_pkg::S_SUM: begin
            // The result waits here while the output register is still occupied.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_offset_in = offset_ff;
               rsp_free_in   = bwa_pkg::FREE_W'(total) << unit_shift_ff;
               state_in      = bwa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bwa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bwa_pkg::S_IDLE;
         free_map_ff   <= {WORD_UNITS{1'b1}};
         end_marks_ff  <= '0;
         unit_shift_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_map_ff  <= free_map_in;
         end_marks_ff <= end_marks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unit_shift_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      alog_ff       <= alog_in;
      addr_ff       <= addr_in;
      units_ff      <= units_in;
      idx_ff        <= idx_in;
      lowmask_ff    <= lowmask_in;
      pos_ff        <= pos_in;
      rel_mask_ff   <= rel_mask_in;
      status_ff     <= status_in;
      offset_ff     <= offset_in;
      part_ff       <= part_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // After a request transaction the block is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while the previous one was still in work");

   // A response only appears from the final step of the sequencer.
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bwa_pkg::S_SUM))
      else $error("response loaded outside the final step");

   // Every candidate position under test leaves room for the whole run.
   a_scan_in_word: assert property (@(posedge clock) disable iff (reset)
      state_ff == bwa_pkg::S_SCAN |->
         (UW + 1)'(pos_ff) + (UW + 1)'(units_ff) <= (UW + 1)'(WORD_UNITS))
      else $error("scan position runs past the end of the word");

endmodule

@@ bench/tb_bitmap_word_allocator.sv @@
// Self-checking testbench for the bitmap word allocator.
`timescale 1ns / 1ps

module tb_bitmap_word_allocator;

   localparam int UNITS = bwa_pkg::WORD_UNITS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_PER_PHASE = 100;

   typedef struct packed {
      logic [bwa_pkg::OP_W-1:0]    op;
      logic [bwa_pkg::SIZE_W-1:0]  size_bytes;
      logic [bwa_pkg::ALIGN_W-1:0] align_log2;
      logic [bwa_pkg::ADDR_W-1:0]  address;
   } alloc_req_type;

   typedef struct packed {
      logic [bwa_pkg::STATUS_W-1:0] status;
      logic [bwa_pkg::ADDR_W-1:0]   offset;
      logic [bwa_pkg::FREE_W-1:0]   free_bytes;
   } alloc_rsp_type;

   typedef struct {
      int unsigned first;
      int unsigned units;
      bit          marked;
   } live_run_type;

   // Tracks the region map and the outcomes that the block still owes.
   class region_tracker;
      logic [63:0]                 free_map;
      logic [63:0]                 end_marks;
      logic [bwa_pkg::SHIFT_W-1:0] unit_shift;
      alloc_rsp_type               expected_outcomes[$];
      live_run_type                live_runs[$];
      int unsigned                 errors;

      function new();
         free_map = '1;
         end_marks = '0;
         unit_shift = '0;
         errors = 0;
      endfunction

      function logic [63:0] run_mask(int unsigned first, int unsigned count);
         if (count == 0) return '0;
         if (count >= 64) return '1;
         return ((64'd1 << count) - 64'd1) << first;
      endfunction

      function logic [bwa_pkg::STATUS_W-1:0] release_run(int unsigned first,
                                                          int unsigned count);
         logic [63:0] m;
         logic [bwa_pkg::STATUS_W-1:0] st;
         if (64'(first) + 64'(count) > UNITS) return bwa_pkg::STATUS_RANGE;
         m = run_mask(first, count);
         st = ((free_map & m) != '0) ? bwa_pkg::STATUS_DOUBLE : bwa_pkg::STATUS_OK;
         free_map |= m;
         return st;
      endfunction

      function alloc_rsp_type predict_outcome(alloc_req_type r);
         int unsigned units;
         logic [63:0] marks;
         logic [63:0] m;
         int unsigned idx;
         int unsigned pos;
         int unsigned step;
         int unsigned mark_gap;
         bit found;
         alloc_rsp_type o;
         live_run_type run;
         units = 32'((64'(r.size_bytes) + (64'd1 << unit_shift) - 64'd1) >> unit_shift);
         idx = 32'((64'(r.address) >> unit_shift) & 64'd63);
         o = '0;
         case (r.op)
            bwa_pkg::OP_ALLOC, bwa_pkg::OP_ALLOC_MARK: begin
               o.status = bwa_pkg::STATUS_NOSPACE;
               if (units != 0 && units <= UNITS && free_map != '0) begin
                  pos = 0;
                  while (!free_map[pos]) pos++;
                  // The search starts at the first free unit, rounded up to the alignment.
                  step = 1 << r.align_log2;
                  pos = (pos + step - 1) / step * step;
                  found = 0;
                  m = '0;
                  while (!found && 64'(pos) + 64'(units) <= UNITS) begin
                     m = run_mask(pos, units);
                     if ((free_map & m) == m) found = 1;
                     else pos += step;
                  end
                  if (found) begin
                     free_map &= ~m;
                     if (r.op == bwa_pkg::OP_ALLOC_MARK) end_marks[pos + units - 1] = 1'b1;
                     o.status = bwa_pkg::STATUS_OK;
                     o.offset = bwa_pkg::ADDR_W'(64'(pos) << unit_shift);
                     run.first = pos;
                     run.units = units;
                     run.marked = (r.op == bwa_pkg::OP_ALLOC_MARK);
                     live_runs.push_back(run);
                  end
               end
            end
            bwa_pkg::OP_FREE_SIZE: begin
               if (64'(idx) + 64'(units) > UNITS) o.status = bwa_pkg::STATUS_RANGE;
               else o.status = release_run(idx, units);
            end
            default: begin
               o.status = bwa_pkg::STATUS_NOMARK;
               if (!free_map[idx]) begin
                  marks = end_marks >> idx;
                  if (marks != '0) begin
                     mark_gap = 0;
                     while (!marks[0]) begin
                        marks >>= 1;
                        mark_gap++;
                     end
                     end_marks[idx + mark_gap] = 1'b0;
                     o.status = release_run(idx, mark_gap + 1);
                  end
               end
            end
         endcase
         o.free_bytes = bwa_pkg::FREE_W'(64'($countones(free_map)) << unit_shift);
         return o;
      endfunction

      function void note_request(alloc_req_type r);
         expected_outcomes.push_back(predict_outcome(r));
      endfunction

      function void report_field(string name, logic [63:0] want, logic [63:0] got);
         errors++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      endfunction

      function void check_response(alloc_rsp_type got);
         alloc_rsp_type want;
         if (expected_outcomes.size() == 0) begin
            report_field("unrequested transaction, status", 'x, 64'(got.status));
            return;
         end
         want = expected_outcomes.pop_front();
         if (got.status !== want.status)
            report_field("status", 64'(want.status), 64'(got.status));
         if (got.offset !== want.offset)
            report_field("offset", 64'(want.offset), 64'(got.offset));
         if (got.free_bytes !== want.free_bytes)
            report_field("free_bytes", 64'(want.free_bytes), 64'(got.free_bytes));
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [bwa_pkg::SHIFT_W-1:0] csr_write_data;

   bwa_req_if req_bus();
   bwa_rsp_if rsp_bus();

   region_tracker sb;
   bit hold_request = 0;
   int unsigned burst_left = 0;
   int unsigned cycle_count = 0;

   bitmap_word_allocator dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic alloc_req_type make_request(logic [bwa_pkg::OP_W-1:0] op,
                                                  int unsigned size,
                                                  int unsigned align, int unsigned addr);
      alloc_req_type r;
      r.op = op;
      r.size_bytes = bwa_pkg::SIZE_W'(size);
      r.align_log2 = bwa_pkg::ALIGN_W'(align);
      r.address = bwa_pkg::ADDR_W'(addr);
      return r;
   endfunction

   // Mostly allocations paired with frees of live runs; the rest is unstructured noise.
   function automatic alloc_req_type next_request();
      alloc_req_type r;
      live_run_type run;
      int unsigned roll;
      int unsigned units;
      int unsigned k;
      int unsigned unit_bytes;
      unit_bytes = 1 << sb.unit_shift;
      roll = $urandom_range(0, 99);
      r.address = bwa_pkg::ADDR_W'($urandom());
      if (roll < 8) begin
         r.op = bwa_pkg::OP_W'($urandom_range(0, 3));
         r.size_bytes = bwa_pkg::SIZE_W'($urandom_range(0, 262144));
         r.align_log2 = bwa_pkg::ALIGN_W'($urandom_range(0, 6));
      end else if (roll < 55 || sb.live_runs.size() == 0) begin
         k = $urandom_range(0, 19);
         if (k < 16) units = $urandom_range(1, 6);
         else if (k < 19) units = $urandom_range(7, 20);
         else units = $urandom_range(21, UNITS);
         r.op = $urandom_range(0, 1) ? bwa_pkg::OP_ALLOC_MARK : bwa_pkg::OP_ALLOC;
         r.size_bytes = bwa_pkg::SIZE_W'((units - 1) * unit_bytes +
                                         $urandom_range(1, unit_bytes));
         r.align_log2 = ($urandom_range(0, 2) == 0) ?
                        bwa_pkg::ALIGN_W'($urandom_range(1, 6)) : '0;
      end else begin
         k = $urandom_range(0, sb.live_runs.size() - 1);
         run = sb.live_runs[k];
         sb.live_runs.delete(k);
         r.address = bwa_pkg::ADDR_W'(run.first * unit_bytes +
                                      $urandom_range(0, unit_bytes - 1));
         r.align_log2 = bwa_pkg::ALIGN_W'($urandom_range(0, 6));
         r.size_bytes = bwa_pkg::SIZE_W'((run.units - 1) * unit_bytes +
                                         $urandom_range(1, unit_bytes));
         r.op = (run.marked && $urandom_range(0, 2) != 0) ?
                bwa_pkg::OP_FREE_MARK : bwa_pkg::OP_FREE_SIZE;
      end
      return r;
   endfunction

   task automatic send_request(alloc_req_type r);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.op <= r.op;
      req_bus.size_bytes <= r.size_bytes;
      req_bus.align_log2 <= r.align_log2;
      req_bus.address <= r.address;
      do @(posedge clock); while (!(req_bus.valid === 1'b1 && req_bus.ready === 1'b1));
      sb.note_request(r);
   endtask

   task automatic idle_request(int unsigned cycles);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic offer(alloc_req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) idle_request($urandom_range(1, 12));
      end
      burst_left--;
      send_request(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (UNITS + 8) @(posedge clock);
   endtask

   task automatic write_unit_shift(int unsigned value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= bwa_pkg::SHIFT_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.unit_shift = bwa_pkg::SHIFT_W'(value);
   endtask

   initial begin : stimulus
      int unsigned shifts[5];
      shifts = '{12, 3, 0, 7, 1};
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.op = bwa_pkg::OP_ALLOC;
      req_bus.size_bytes = '0;
      req_bus.align_log2 = '0;
      req_bus.address = '0;
      sb = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      write_unit_shift(0);
      offer(make_request(bwa_pkg::OP_ALLOC, 0, 0, 0));          // zero units
      offer(make_request(bwa_pkg::OP_ALLOC, 65, 0, 0));         // more units than the word
      offer(make_request(bwa_pkg::OP_ALLOC, 262144, 0, 0));
      offer(make_request(bwa_pkg::OP_ALLOC_MARK, 64, 0, 0));    // whole word
      offer(make_request(bwa_pkg::OP_ALLOC, 1, 0, 0));          // map is full
      offer(make_request(bwa_pkg::OP_FREE_MARK, 0, 0, 0));
      offer(make_request(bwa_pkg::OP_FREE_SIZE, 0, 0, 0));      // zero units freed
      offer(make_request(bwa_pkg::OP_FREE_SIZE, 2, 0, 63));     // beyond the word
      offer(make_request(bwa_pkg::OP_FREE_SIZE, 3, 0, 5));      // double free
      offer(make_request(bwa_pkg::OP_FREE_MARK, 0, 0, 10));     // unit is free
      offer(make_request(bwa_pkg::OP_ALLOC, 3, 0, 0));
      offer(make_request(bwa_pkg::OP_ALLOC_MARK, 5, 2, 0));
      offer(make_request(bwa_pkg::OP_ALLOC, 1, 6, 0));          // alignment rounds past the word
      offer(make_request(bwa_pkg::OP_ALLOC, 2, 1, 0));
      offer(make_request(bwa_pkg::OP_FREE_MARK, 0, 0, 0));      // spans a free unit
      offer(make_request(bwa_pkg::OP_FREE_MARK, 0, 0, 10));     // no mark after the unit
      offer(make_request(bwa_pkg::OP_FREE_SIZE, 2, 0, 10));
      offer(make_request(bwa_pkg::OP_FREE_MARK, 524287, 7, 262143));
      offer(make_request(bwa_pkg::OP_ALLOC, 1, 6, 0));
      offer(make_request(bwa_pkg::OP_ALLOC_MARK, 63, 0, 0));
      offer(make_request(bwa_pkg::OP_FREE_SIZE, 1, 0, 262143));
      offer(make_request(bwa_pkg::OP_FREE_MARK, 0, 0, 1));
      offer(make_request(bwa_pkg::OP_FREE_SIZE, 1, 0, 0));
      offer(make_request(bwa_pkg::OP_ALLOC, 7, 3, 262143));
      offer(make_request(bwa_pkg::OP_FREE_SIZE, 7, 0, 0));
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         write_unit_shift(shifts[ph]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (ph == 1 && n == 30) hold_request = 1;
            if (ph == 2 && n == 50) wait_drained();
            offer(next_request());
         end
         wait_drained();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("bitmap_word_allocator: match");
      end else begin
         $display("bitmap_word_allocator: mismatch");
      end
      $finish;
   end

   // The receiver alternates between stall patterns and takes one long hold on request.
   initial begin : receiver_pattern
      int unsigned mode;
      int unsigned left;
      mode = 0;
      left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 15) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      alloc_rsp_type got;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.status = rsp_bus.status;
         got.offset = rsp_bus.offset;
         got.free_bytes = rsp_bus.free_bytes;
         sb.check_response(got);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bitmap_word_allocator: mismatch");
      $finish;
   end

endmodule

@@ bitmap_word_allocator.f @@
sv/bwa_pkg.sv
sv/bwa_channels.sv
sv/bitmap_word_allocator.sv
bench/tb_bitmap_word_allocator.sv
